FILE: rtl/cpifd_pkg.sv
// ----------------------------------------------------------------------------
// cpifd_pkg
// Shared types, sizes and codes of the process-image frame decoder.
// ----------------------------------------------------------------------------
package cpifd_pkg;

   // process-image table sizes
   localparam int DI_POINTS      = 64;
   localparam int DO_POINTS      = 64;
   localparam int AI_CHANNELS    = 16;
   localparam int BIT_TABLE_SIZE = 128;
   localparam int REG_TABLE_SIZE = 64;

   // entries written by a used-mask frame
   localparam int AI_USED_N = (AI_CHANNELS < 16) ? AI_CHANNELS : 16;
   localparam int DI_USED_N = (DI_POINTS < 16) ? DI_POINTS : 16;
   localparam logic [15:0] AI_USED_MASK = 16'((33'd1 << AI_USED_N) - 33'd1);
   localparam logic [15:0] DI_USED_MASK = 16'((33'd1 << DI_USED_N) - 33'd1);

   // frame id service codes
   localparam logic [2:0] SVC_CHAN_SETUP = 3'h0;
   localparam logic [2:0] SVC_LINK_BEAT  = 3'h1;

   // object ids in byte0
   localparam logic [4:0] OID_DIGITAL  = 5'h01;
   localparam logic [4:0] OID_CLUS_BIT = 5'h03;
   localparam logic [4:0] OID_AI       = 5'h05;
   localparam logic [4:0] OID_CLUS_REG = 5'h06;
   localparam logic [4:0] OID_USED     = 5'h0A;
   localparam logic [4:0] OID_NET_BIT  = 5'h0E;
   localparam logic [4:0] OID_NET_REG  = 5'h0F;
   localparam logic [4:0] OID_APP_INFO = 5'h1F;

   // app-info addresses
   localparam logic [7:0] APP_ID_ADDR   = 8'd3;
   localparam logic [7:0] IP_STATE_ADDR = 8'd17;

   // used-mask table selectors
   localparam logic [7:0] SEL_AI_TABLE = 8'd0;
   localparam logic [7:0] SEL_DI_TABLE = 8'd1;

   // command queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      KIND_HEARTBEAT = 4'd0,
      KIND_DI        = 4'd1,
      KIND_DO        = 4'd2,
      KIND_CLUS_BIT  = 4'd3,
      KIND_AI        = 4'd4,
      KIND_CLUS_REG  = 4'd5,
      KIND_AI_USED   = 4'd6,
      KIND_DI_USED   = 4'd7,
      KIND_NET_BIT   = 4'd8,
      KIND_NET_REG   = 4'd9,
      KIND_APP_ID    = 4'd10,
      KIND_IP_STATE  = 4'd11
   } kind_type;

   // one classified frame: a mask of slots that each give one write
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  base;
      logic [15:0] mask;
      logic [7:0]  do_mask;
      logic        bitwise;
      logic [15:0] word;
      logic [15:0] fault;
      logic [7:0]  tdu;
      logic [7:0]  level;
      logic [7:0]  pt_state;
      logic [7:0]  pt_fault;
      logic [3:0]  node;
      logic        names_req;
   } job_type;

endpackage

FILE: rtl/cpifd_if.sv
// ----------------------------------------------------------------------------
// cpifd_if
// Frame and write-command channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpifd_req_if;
   logic       valid;
   logic       ready;
   logic [10:0] frame_id;
   logic [7:0] byte0;
   logic [7:0] byte1;
   logic [7:0] byte2;
   logic [7:0] byte3;
   logic [7:0] byte4;
   logic [7:0] byte5;
   logic [7:0] byte6;
   logic [7:0] byte7;

   modport source (output valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5,
                   byte6, byte7, input ready);
   modport sink (input valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5,
                 byte6, byte7, output ready);
endinterface

interface cpifd_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  target_kind;
   logic [7:0]  target_index;
   logic [15:0] word_value;
   logic [15:0] fault_word;
   logic [7:0]  tdu_byte;
   logic [7:0]  level_byte;
   logic        point_fault;
   logic        point_state;
   logic [3:0]  node_address;
   logic        names_request;
   logic        last;

   modport source (output valid, target_kind, target_index, word_value, fault_word,
                   tdu_byte, level_byte, point_fault, point_state, node_address,
                   names_request, last, input ready);
   modport sink (input valid, target_kind, target_index, word_value, fault_word,
                 tdu_byte, level_byte, point_fault, point_state, node_address,
                 names_request, last, output ready);
endinterface

FILE: rtl/cpifd_front.sv
// ----------------------------------------------------------------------------
// cpifd_front
// Accepts frames, tracks the link flag and classifies each frame into a job.
// ----------------------------------------------------------------------------
module cpifd_front import cpifd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   cpifd_req_if.sink req_ch,
   output logic    push_valid,
   input  logic    push_ready,
   output job_type push_job
);

   logic              link_up_ff, link_up_in;
   logic [2:0]        srv;
   logic [3:0]        node;
   logic [2:0]        clus;
   logic [4:0]        oid;
   logic [7:0]        addr;
   logic [15:0]       w23;
   logic              accept;
   logic signed [9:0] net_base;
   logic signed [9:0] creg_idx;
   logic [8:0]        lane_p;
   logic signed [9:0] lane_c;
   logic signed [9:0] lane_n;
   logic [7:0]        dig_ok, dig_do, cbit_ok, nbit_ok;
   job_type           job;

   assign srv  = req_ch.frame_id[2:0];
   assign node = req_ch.frame_id[6:3];
   assign clus = req_ch.frame_id[9:7];
   assign oid  = req_ch.byte0[4:0];
   assign addr = req_ch.byte1;
   assign w23  = {req_ch.byte3, req_ch.byte2};

   assign net_base = $signed({2'b00, addr}) - $signed({3'b000, clus, 4'b0000}) - 10'sd1;
   assign creg_idx = $signed({2'b00, addr}) - 10'sd17;

   // per-lane range checks for the eight-point frames
   always_comb begin
      dig_ok  = '0;
      dig_do  = '0;
      cbit_ok = '0;
      nbit_ok = '0;
      lane_p  = '0;
      lane_c  = '0;
      lane_n  = '0;
      for (int i = 0; i < 8; i++) begin
         lane_p = {1'b0, addr} + 9'(i);
         lane_c = $signed({2'b00, addr}) + $signed(10'(i)) - 10'sd16;
         lane_n = net_base + $signed(10'(i));
         dig_do[i] = (lane_p >= 9'd129) && ({1'b0, lane_p} < 10'(129 + DO_POINTS));
         dig_ok[i] = req_ch.byte4[i] &&
                     (((lane_p >= 9'd1) && (lane_p <= 9'(DI_POINTS))) || dig_do[i]);
         cbit_ok[i] = req_ch.byte3[i] && (lane_c >= 10'sd0) &&
                      (lane_c < $signed(10'(BIT_TABLE_SIZE)));
         nbit_ok[i] = req_ch.byte3[i] && (lane_n >= 10'sd0) &&
                      (lane_n < $signed(10'(BIT_TABLE_SIZE)));
      end
   end

   always_comb begin
      job      = '0;
      job.kind = KIND_HEARTBEAT;
      priority if (srv == SVC_CHAN_SETUP) begin
         job.mask = '0;
      end else if (srv == SVC_LINK_BEAT) begin
         job.kind      = KIND_HEARTBEAT;
         job.base      = {5'b00000, clus};
         job.word      = {8'h00, addr};
         job.node      = node;
         job.names_req = link_up_ff;
         job.mask      = 16'h0001;
      end else begin
         unique case (oid)
            OID_DIGITAL: begin
               job.kind     = KIND_DI;
               job.base     = addr - 8'd1;
               job.mask     = {8'h00, dig_ok};
               job.do_mask  = dig_do;
               job.pt_state = req_ch.byte2;
               job.pt_fault = req_ch.byte3;
            end
            OID_CLUS_BIT: begin
               job.kind    = KIND_CLUS_BIT;
               job.base    = addr - 8'd16;
               job.mask    = {8'h00, cbit_ok};
               job.word    = {8'h00, req_ch.byte2};
               job.bitwise = 1'b1;
            end
            OID_AI: begin
               job.kind  = KIND_AI;
               job.base  = addr - 8'd1;
               job.word  = {req_ch.byte7, req_ch.byte6};
               job.fault = {req_ch.byte5, req_ch.byte4};
               job.tdu   = req_ch.byte3;
               job.level = req_ch.byte2;
               job.mask  = {15'd0, (addr >= 8'd1) && ({1'b0, addr} <= 9'(AI_CHANNELS))};
            end
            OID_CLUS_REG: begin
               job.kind = KIND_CLUS_REG;
               job.base = creg_idx[7:0];
               job.word = w23;
               job.mask = {15'd0, (creg_idx >= 10'sd0) &&
                                  (creg_idx < $signed(10'(REG_TABLE_SIZE)))};
            end
            OID_USED: begin
               job.word    = w23;
               job.bitwise = 1'b1;
               if (req_ch.byte4 == SEL_AI_TABLE) begin
                  job.kind = KIND_AI_USED;
                  job.mask = AI_USED_MASK;
               end else if (req_ch.byte4 == SEL_DI_TABLE) begin
                  job.kind = KIND_DI_USED;
                  job.mask = DI_USED_MASK;
               end
            end
            OID_NET_BIT: begin
               job.kind    = KIND_NET_BIT;
               job.base    = net_base[7:0];
               job.mask    = {8'h00, nbit_ok};
               job.word    = {8'h00, req_ch.byte2};
               job.bitwise = 1'b1;
            end
            OID_NET_REG: begin
               job.kind = KIND_NET_REG;
               job.base = net_base[7:0];
               job.word = w23;
               job.mask = {15'd0, (net_base >= 10'sd0) &&
                                  (net_base < $signed(10'(REG_TABLE_SIZE)))};
            end
            OID_APP_INFO: begin
               if (addr == APP_ID_ADDR) begin
                  job.kind = KIND_APP_ID;
                  job.word = w23;
                  job.mask = 16'h0001;
               end else if (addr == IP_STATE_ADDR) begin
                  job.kind = KIND_IP_STATE;
                  job.word = {8'h00, req_ch.byte2};
                  job.mask = 16'h0001;
               end
            end
            default: begin
               job.mask = '0;
            end
         endcase
      end
   end

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;
   assign push_valid   = accept && (job.mask != '0);
   assign push_job     = job;

   assign link_up_in = (accept && (srv == SVC_LINK_BEAT)) ? 1'b1 : link_up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_up_ff <= 1'b0;
      end else begin
         link_up_ff <= link_up_in;
      end
   end

endmodule

FILE: rtl/cpifd_fifo.sv
// ----------------------------------------------------------------------------
// cpifd_fifo
// Short job queue between the classifying front end and the write back end.
// ----------------------------------------------------------------------------
module cpifd_fifo import cpifd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/cpifd_back.sv
// ----------------------------------------------------------------------------
// cpifd_back
// Walks each job's slot mask, issuing one write per cycle while rsp_ch is free.
// ----------------------------------------------------------------------------
module cpifd_back import cpifd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    pop_valid,
   output logic    pop_ready,
   input  job_type pop_job,
   cpifd_rsp_if.source rsp_ch
);

   job_type     job_ff;
   logic        job_valid_ff;
   logic [15:0] rem_ff, rem_in;
   logic        rsp_valid_ff;
   logic [3:0]  slot;
   logic [15:0] slot_bit;
   logic        out_free, emit, last_slot, dig, is_do, is_ai;
   logic [7:0]  idx;

   logic [3:0]  kind_ff;
   logic [7:0]  index_ff;
   logic [15:0] word_ff;
   logic [15:0] fault_ff;
   logic [7:0]  tdu_ff;
   logic [7:0]  level_ff;
   logic        pfault_ff, pstate_ff;
   logic [3:0]  node_ff;
   logic        names_ff;
   logic        last_ff;

   // lowest pending slot
   always_comb begin
      slot = '0;
      for (int k = 15; k >= 0; k--) begin
         if (rem_ff[k]) begin
            slot = 4'(k);
         end
      end
   end

   assign slot_bit  = 16'd1 << slot;
   assign rem_in    = rem_ff & ~slot_bit;
   assign last_slot = (rem_in == '0);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign emit      = job_valid_ff && out_free;
   assign pop_ready = !job_valid_ff || (emit && last_slot);

   assign dig   = (job_ff.kind == KIND_DI);
   assign is_do = dig && job_ff.do_mask[slot[2:0]];
   assign is_ai = (job_ff.kind == KIND_AI);
   // do points sit 128 above di points in the address space
   assign idx   = (job_ff.base + {4'b0000, slot}) ^ {is_do, 7'b0000000};

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pop_ready) begin
            job_valid_ff <= pop_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         job_ff <= pop_job;
         rem_ff <= pop_job.mask;
      end else if (emit) begin
         rem_ff <= rem_in;
      end
      if (emit) begin
         kind_ff   <= is_do ? KIND_DO : job_ff.kind;
         index_ff  <= idx;
         word_ff   <= job_ff.bitwise ? {15'd0, job_ff.word[slot]} : job_ff.word;
         fault_ff  <= is_ai ? job_ff.fault : 16'h0000;
         tdu_ff    <= is_ai ? job_ff.tdu : 8'h00;
         level_ff  <= is_ai ? job_ff.level : 8'h00;
         pfault_ff <= dig && job_ff.pt_fault[slot[2:0]];
         pstate_ff <= dig && job_ff.pt_state[slot[2:0]] && !job_ff.pt_fault[slot[2:0]];
         node_ff   <= job_ff.node;
         names_ff  <= job_ff.names_req;
         last_ff   <= last_slot;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.target_kind   = kind_ff;
   assign rsp_ch.target_index  = index_ff;
   assign rsp_ch.word_value    = word_ff;
   assign rsp_ch.fault_word    = fault_ff;
   assign rsp_ch.tdu_byte      = tdu_ff;
   assign rsp_ch.level_byte    = level_ff;
   assign rsp_ch.point_fault   = pfault_ff;
   assign rsp_ch.point_state   = pstate_ff;
   assign rsp_ch.node_address  = node_ff;
   assign rsp_ch.names_request = names_ff;
   assign rsp_ch.last          = last_ff;

endmodule

FILE: rtl/can_process_image_frame_decoder.sv
// ----------------------------------------------------------------------------
// can_process_image_frame_decoder
// Splits received CAN frames into write commands for the process image.
// ----------------------------------------------------------------------------
//  channel   dir   beat
//  req_ch    in    one frame: frame_id, byte0..byte7
//  rsp_ch    out   one write command, last on the final one of a frame
//
//  a frame is taken in a single handshake and queued as a job; the back end issues
//  one command per cycle while rsp_ch is free, so a frame with n commands holds
//  the back end until all n are issued (1 to 16); frames with no command are dropped
//  reset clears the link flag, the job queue and the output register
//  the output register frees when rsp_ch.ready is high; a full queue drops req_ch.ready
// ----------------------------------------------------------------------------
module can_process_image_frame_decoder import cpifd_pkg::*; (
   input logic clock,
   input logic reset,
   cpifd_req_if.sink   req_ch,
   cpifd_rsp_if.source rsp_ch
);

   logic    push_valid, push_ready;
   logic    pop_valid, pop_ready;
   job_type push_job, pop_job;

   cpifd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   cpifd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   cpifd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_ch    (rsp_ch)
   );

`ifndef SYNTHESIS
   a_fault_hides_state: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.point_fault |-> !rsp_ch.point_state)
      else $error("faulted point carries a state");

   a_analog_only: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.target_kind != KIND_AI) |->
         (rsp_ch.fault_word == 16'h0000) && (rsp_ch.tdu_byte == 8'h00) &&
         (rsp_ch.level_byte == 8'h00))
      else $error("analog fields set on a non-analog command");

   a_heartbeat_single: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.target_kind == KIND_HEARTBEAT) |-> rsp_ch.last)
      else $error("heartbeat command not marked last");

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("job pushed into a full queue");
`endif

endmodule
